### rtl/rrol_pkg.sv
package rrol_pkg;

   typedef struct packed {
      logic        mode;
      logic [15:0] record_length;
      logic [31:0] record_handle;
      logic [19:0] byte_position;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_index;
      logic [31:0] found_handle;
      logic [15:0] offset_in_record;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] length;
      logic [31:0] handle;
   } desc_type;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_FIND = 1'b1;

   localparam logic [1:0] STATUS_ADDED     = 2'd0;
   localparam logic [1:0] STATUS_FOUND     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

endpackage

### rtl/record_ring_offset_lookup_unit.sv
// channel   ports                               word            direction
// request   req_valid, req_stall, req_word      req_word_type   in
// response  rsp_valid, rsp_stall, rsp_word      rsp_word_type   out
//
// An add writes its descriptor on acceptance and gets a registered response.
// A find walks the stored records in order from the oldest, reading one at a time
// through the single read port of the descriptor memory.
// Reset clears the ring pointers and full flag at once; no clearing pass.
// A stalled response is held in the output register; one more result waits
// in a holding register while the next request is stalled.
module record_ring_offset_lookup_unit #(
   parameter int RING_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrol_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrol_pkg::rsp_word_type rsp_word
);

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

   rrol_pkg::state_type    state_ff, state_in;
   logic [19:0]            pos_ff, pos_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   rrol_pkg::rsp_word_type pend_ff, pend_in;
   rrol_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   wr_en;
   rrol_pkg::desc_type     wr_data;
   logic [SLOT_W-1:0]      rd_addr;
   rrol_pkg::desc_type     rd_data;
   logic [SLOT_W-1:0]      write_slot;
   logic [SLOT_W-1:0]      oldest_slot;
   logic                   ring_full;
   logic [CNT_W-1:0]       valid_count;
   logic [SLOT_W-1:0]      slot_next;
   logic                   out_free;
   logic                   res_valid;
   rrol_pkg::rsp_word_type res;

   rrol_desc_mem #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (SLOT_W)
   ) u_desc_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_slot),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rrol_ring_ptr #(
      .RING_DEPTH (RING_DEPTH),
      .SLOT_W     (SLOT_W),
      .CNT_W      (CNT_W)
   ) u_ring_ptr (
      .clock       (clock),
      .reset       (reset),
      .advance     (wr_en),
      .write_slot  (write_slot),
      .oldest_slot (oldest_slot),
      .ring_full   (ring_full),
      .valid_count (valid_count)
   );

   assign wr_data.length = req_word.record_length;
   assign wr_data.handle = req_word.record_handle;
   assign slot_next      = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign req_stall      = (state_ff != rrol_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      rd_addr      = slot_next;
      res_valid    = 1'b0;
      res          = '0;

      unique case (state_ff)
         rrol_pkg::ST_IDLE: begin
            rd_addr = oldest_slot;
            if (req_valid) begin
               if (req_word.mode == rrol_pkg::MODE_ADD) begin
                  wr_en      = 1'b1;
                  res_valid  = 1'b1;
                  res.status = rrol_pkg::STATUS_ADDED;
               end else if (valid_count == '0) begin
                  res_valid  = 1'b1;
                  res.status = rrol_pkg::STATUS_NOT_FOUND;
               end else begin
                  state_in = rrol_pkg::ST_WALK;
                  pos_in   = req_word.byte_position;
                  slot_in  = oldest_slot;
                  left_in  = valid_count;
               end
            end
         end
         rrol_pkg::ST_WALK: begin
            if (pos_ff < 20'(rd_data.length)) begin
               res_valid            = 1'b1;
               res.status           = rrol_pkg::STATUS_FOUND;
               res.slot_index       = 4'(slot_ff);
               res.found_handle     = rd_data.handle;
               res.offset_in_record = pos_ff[15:0];
            end else if (left_ff == CNT_W'(1)) begin
               res_valid  = 1'b1;
               res.status = rrol_pkg::STATUS_NOT_FOUND;
            end else begin
               pos_in  = pos_ff - 20'(rd_data.length);
               slot_in = slot_next;
               left_in = left_ff - 1'b1;
            end
         end
         rrol_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = rrol_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrol_pkg::ST_IDLE;
         end
      endcase

      if (res_valid) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = rrol_pkg::ST_IDLE;
         end else begin
            pend_in  = res;
            state_in = rrol_pkg::ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrol_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff  <= pos_in;
      slot_ff <= slot_in;
      left_ff <= left_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_walk_has_records: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrol_pkg::ST_WALK |-> left_ff != '0)
      else $error("walk running with no records left");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == rrol_pkg::ST_IDLE && req_valid)
      else $error("descriptor write outside an accepted add");

   a_full_pointers: assert property (@(posedge clock) disable iff (reset)
      ring_full |-> write_slot == oldest_slot)
      else $error("full ring with write and oldest slots apart");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != rrol_pkg::ST_IDLE || rsp_valid_ff)
      else $error("accepted request left no trace");

endmodule

### rtl/rrol_desc_mem.sv
module rrol_desc_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  rrol_pkg::desc_type    wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output rrol_pkg::desc_type    rd_data
);

   rrol_pkg::desc_type mem [DEPTH];
   rrol_pkg::desc_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rrol_ring_ptr.sv
module rrol_ring_ptr #(
   parameter int RING_DEPTH = 16,
   parameter int SLOT_W     = 4,
   parameter int CNT_W      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   output logic [SLOT_W-1:0] write_slot,
   output logic [SLOT_W-1:0] oldest_slot,
   output logic              ring_full,
   output logic [CNT_W-1:0]  valid_count
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

   logic [SLOT_W-1:0] write_ff, write_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic              full_ff, full_in;
   logic [SLOT_W-1:0] write_next;
   logic [SLOT_W-1:0] oldest_next;

   assign write_next  = (write_ff == LAST_SLOT) ? '0 : write_ff + 1'b1;
   assign oldest_next = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;

   always_comb begin
      write_in  = write_ff;
      oldest_in = oldest_ff;
      full_in   = full_ff;
      if (advance) begin
         write_in = write_next;
         if (full_ff) begin
            oldest_in = oldest_next;
         end else if (write_next == oldest_ff) begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ff  <= '0;
         oldest_ff <= '0;
         full_ff   <= 1'b0;
      end else begin
         write_ff  <= write_in;
         oldest_ff <= oldest_in;
         full_ff   <= full_in;
      end
   end

   always_comb begin
      if (full_ff) begin
         valid_count = CNT_W'(RING_DEPTH);
      end else if (write_ff >= oldest_ff) begin
         valid_count = CNT_W'(write_ff) - CNT_W'(oldest_ff);
      end else begin
         valid_count = CNT_W'(write_ff) + CNT_W'(RING_DEPTH) - CNT_W'(oldest_ff);
      end
   end

   assign write_slot  = write_ff;
   assign oldest_slot = oldest_ff;
   assign ring_full   = full_ff;

endmodule
